@@ hdl/pc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_pkg
// Shared types and codes for the polygon centroid block.
// ----------------------------------------------------------------------------
package pc_pkg;

    // which rule produced a centroid beat
    typedef enum logic [1:0] {
        KIND_AREA      = 2'd0,
        KIND_POINT     = 2'd1,
        KIND_MIDPOINT  = 2'd2,
        KIND_COLLINEAR = 2'd3
    } case_kind_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ hdl/pc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_if
// Valid/ready channels for vertex beats in and centroid beats out.
// ----------------------------------------------------------------------------
interface vertex_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

interface centroid_if #(
    parameter int COORD_WIDTH = 24
);
    import pc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] centroid_x;
    logic signed [COORD_WIDTH-1:0] centroid_y;
    case_kind_t                    case_kind;

    modport source (output valid, output centroid_x, output centroid_y, output case_kind,
                    input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, input case_kind,
                    output ready);
endinterface

@@ hdl/pc_vstore.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_vstore
// Vertex memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pc_vstore #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_div
// Signed divider, quotient rounded toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pc_div #(
    parameter int NUM_W = 84,
    parameter int DEN_W = 63
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [NUM_W:0]   quo,
    output pc_pkg::div_status_t     status
);
    import pc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dm_reg;
    logic             neg_reg;
    logic signed [NUM_W:0] quo_reg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             ge;

    // magnitudes of the operands
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // restoring step
    assign shifted = {rem_reg, nq_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, dm_reg};
    assign ge      = !trial[DEN_W];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num_mag;
            dm_reg  <= den_mag;
            rem_reg <= '0;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
        if (fin_reg)
        begin
            quo_reg <= neg_reg ? -$signed({1'b0, nq_reg}) : $signed({1'b0, nq_reg});
        end
    end

    assign quo         = quo_reg;
    assign status.busy = busy_reg | fin_reg;
    assign status.done = done_reg;

endmodule

@@ hdl/polygon_centroid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_centroid
// Stores polygon vertices and on the last one emits the shoelace centroid,
// a lone point, a midpoint, or the farthest-pair midpoint when collinear.
// ----------------------------------------------------------------------------
//  channel   dir  payload                               handshake
//  vertex    in   vertex_x, vertex_y, last_vertex       valid/ready
//  centroid  out  centroid_x, centroid_y, case_kind     valid/ready
//
//  Vertex beats go straight into the vertex memory, back to back while idle.
//  After the last vertex: an area pass over all vertices, then either two
//  divisions, x then y, or a scan of every vertex pair followed by a read of
//  the farthest pair; fewer than three vertices go straight to that read.
//  Area pass, pair scan and final read use the single memory read port.
//  Reset clears the vertex count and all control; memory contents are kept.
//  A result waiting in the output register holds the next result in the done
//  state, and the vertex input stalls until that result moves on.
// ----------------------------------------------------------------------------
module polygon_centroid #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 24
) (
    input  logic clk,
    input  logic rst_n,
    vertex_if.sink     vertex,
    centroid_if.source centroid
);
    import pc_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int CB     = $clog2(MAX_VERTICES) + 1;
    localparam int PW     = 2 * W;
    localparam int XW     = 2 * W + 1;
    localparam int AREA_W = XW + CB;
    localparam int DEN_W  = AREA_W + 2;
    localparam int TERM_W = 3 * W + 3;
    localparam int SUM_W  = TERM_W + CB;
    localparam int QW     = SUM_W + 1;
    localparam int SQ_W   = 2 * W + 1;
    localparam int DIST_W = 2 * W + 2;

    localparam logic signed [QW-1:0] QMAX = {{(QW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {{(QW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0]  CMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  CMIN = {1'b1, {(W - 1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_AREA = 8'b0000_0010,
        S_DEN  = 8'b0000_0100,
        S_DIVX = 8'b0000_1000,
        S_DIVY = 8'b0001_0000,
        S_PAIR = 8'b0010_0000,
        S_MID  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // input side
    logic          in_acc;
    logic          full;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_now;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_m1;

    // memory ports
    logic [AW-1:0]  rd_addr;
    logic [PW-1:0]  rdata;
    logic signed [W-1:0] rd_x, rd_y;

    // area pass
    logic          area_iss;
    logic          area_done_reg;
    logic [CW-1:0] ai_reg;
    logic          area_rv_reg, area_nz_reg;
    logic signed [W-1:0]  prev_x_reg, prev_y_reg;
    logic                 a1_v_reg, a2_v_reg, a3_v_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [W:0]    sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic signed [XW-1:0] cross_reg, cross3_reg;
    logic signed [W+1:0]  cross_lo;
    logic signed [W-1:0]  cross_hi;
    logic signed [2*W+2:0] plx_reg, ply_reg;
    logic signed [2*W:0]   phx_reg, phy_reg;
    logic signed [TERM_W-1:0] term_x, term_y;
    logic signed [AREA_W-1:0] area_reg;
    logic signed [SUM_W-1:0]  sumx_reg, sumy_reg;
    logic                     area_drained;
    logic signed [DEN_W-1:0]  den_reg;

    // divider
    logic                   div_start;
    logic signed [SUM_W-1:0] div_num;
    logic signed [QW-1:0]   quo;
    div_status_t            div_st;
    logic signed [W-1:0]    quo_sat;

    // pair scan
    logic          pair_iss;
    logic          pdone_reg, lp_reg;
    logic [AW-1:0] oi_reg, pj_reg;
    logic          pair_rv_reg, pair_ld_reg;
    logic [AW-1:0] t0i_reg, t0j_reg, t1i_reg, t1j_reg, t2i_reg, t2j_reg;
    logic signed [W-1:0] pix_reg, piy_reg;
    logic                p1_v_reg, p2_v_reg;
    logic signed [W:0]   dx_reg, dy_reg;
    logic signed [2*W+1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [DIST_W-1:0]   pair_dsq, best_reg;
    logic [AW-1:0]       bi_reg, bj_reg;
    logic                pair_drained;

    // midpoint and result
    logic [1:0]          mstep_reg;
    logic signed [W-1:0] hold_x_reg, hold_y_reg;
    logic signed [W:0]   mid_sx, mid_sy;
    logic signed [W-1:0] res_x_reg, res_y_reg;
    case_kind_t          res_kind_reg;
    logic                out_v_reg, out_load;
    logic signed [W-1:0] out_x_reg, out_y_reg;
    case_kind_t          out_kind_reg;

    // input handshake and fill count
    assign vertex.ready = (state_reg == S_IDLE);
    assign in_acc       = vertex.valid && vertex.ready;
    assign full         = (count_reg == CW'(MAX_VERTICES));
    assign n_now        = full ? count_reg : count_reg + CW'(1);
    assign n_m1         = n_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_acc)
        begin
            count_reg <= vertex.last_vertex ? '0 : n_now;
        end
    end

    // vertex memory
    always_comb
    begin
        case (state_reg)
            S_AREA:  rd_addr = (ai_reg == n_reg) ? '0 : ai_reg[AW-1:0];
            S_PAIR:  rd_addr = lp_reg ? oi_reg : pj_reg;
            S_MID:   rd_addr = (mstep_reg == 2'd0) ? bi_reg : bj_reg;
            default: rd_addr = '0;
        endcase
    end

    pc_vstore #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (AW),
        .DATA_W (PW)
    ) u_vstore (
        .clk   (clk),
        .we    (in_acc && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata ({vertex.vertex_y, vertex.vertex_x}),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign rd_x = rdata[W-1:0];
    assign rd_y = rdata[PW-1:W];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && vertex.last_vertex)
                begin
                    state_next = (n_now >= CW'(3)) ? S_AREA : S_MID;
                end
            end
            S_AREA:
            begin
                if (area_drained)
                begin
                    state_next = (area_reg == '0) ? S_PAIR : S_DEN;
                end
            end
            S_DEN:  state_next = S_DIVX;
            S_DIVX: if (div_st.done) state_next = S_DIVY;
            S_DIVY: if (div_st.done) state_next = S_DONE;
            S_PAIR: if (pair_drained) state_next = S_MID;
            S_MID:  if (mstep_reg == 2'd2) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // area pass read issue: vertices 0..n-1 then vertex 0 again
    assign area_iss = (state_reg == S_AREA) && !area_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_done_reg <= 1'b0;
            ai_reg        <= '0;
            area_rv_reg   <= 1'b0;
            a1_v_reg      <= 1'b0;
            a2_v_reg      <= 1'b0;
            a3_v_reg      <= 1'b0;
        end
        else
        begin
            if (state_reg == S_IDLE)
            begin
                area_done_reg <= 1'b0;
                ai_reg        <= '0;
            end
            else if (area_iss)
            begin
                ai_reg <= ai_reg + CW'(1);
                if (ai_reg == n_reg)
                begin
                    area_done_reg <= 1'b1;
                end
            end
            area_rv_reg <= area_iss;
            a1_v_reg    <= area_rv_reg && area_nz_reg;
            a2_v_reg    <= a1_v_reg;
            a3_v_reg    <= a2_v_reg;
        end
    end

    // area pipeline: cross products, split multiply, accumulate
    assign cross_lo = $signed({1'b0, cross_reg[W:0]});
    assign cross_hi = $signed(cross_reg[XW-1:W+1]);
    assign term_x   = (TERM_W'(phx_reg) <<< (W + 1)) + TERM_W'(plx_reg);
    assign term_y   = (TERM_W'(phy_reg) <<< (W + 1)) + TERM_W'(ply_reg);
    assign area_drained = area_done_reg && !area_rv_reg && !a1_v_reg && !a2_v_reg
                          && !a3_v_reg;

    always_ff @(posedge clk)
    begin
        area_nz_reg <= (ai_reg != '0);
        if (area_rv_reg)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            m1_reg     <= prev_x_reg * rd_y;
            m2_reg     <= rd_x * prev_y_reg;
            sx1_reg    <= (W+1)'(prev_x_reg) + (W+1)'(rd_x);
            sy1_reg    <= (W+1)'(prev_y_reg) + (W+1)'(rd_y);
        end
        cross_reg  <= XW'(m1_reg) - XW'(m2_reg);
        sx2_reg    <= sx1_reg;
        sy2_reg    <= sy1_reg;
        plx_reg    <= sx2_reg * cross_lo;
        ply_reg    <= sy2_reg * cross_lo;
        phx_reg    <= sx2_reg * cross_hi;
        phy_reg    <= sy2_reg * cross_hi;
        cross3_reg <= cross_reg;
        if (state_reg == S_IDLE)
        begin
            area_reg <= '0;
            sumx_reg <= '0;
            sumy_reg <= '0;
        end
        else if (a3_v_reg)
        begin
            area_reg <= area_reg + AREA_W'(cross3_reg);
            sumx_reg <= sumx_reg + SUM_W'(term_x);
            sumy_reg <= sumy_reg + SUM_W'(term_y);
        end
        if (area_drained)
        begin
            den_reg <= (DEN_W'(area_reg) <<< 1) + DEN_W'(area_reg);
        end
    end

    // shared divider, x first then y
    assign div_start = (state_reg == S_DEN) || ((state_reg == S_DIVX) && div_st.done);
    assign div_num   = (state_reg == S_DEN) ? sumx_reg : sumy_reg;

    pc_div #(
        .NUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (den_reg),
        .quo    (quo),
        .status (div_st)
    );

    // saturate quotient to coordinate range
    always_comb
    begin
        if (quo > QMAX)
        begin
            quo_sat = CMAX;
        end
        else if (quo < QMIN)
        begin
            quo_sat = CMIN;
        end
        else
        begin
            quo_sat = quo[W-1:0];
        end
    end

    // pair scan read issue: load vertex i, then scan j = i+1..n-1
    assign pair_iss = (state_reg == S_PAIR) && !pdone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdone_reg   <= 1'b0;
            lp_reg      <= 1'b1;
            oi_reg      <= '0;
            pair_rv_reg <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == S_IDLE)
            begin
                pdone_reg <= 1'b0;
                lp_reg    <= 1'b1;
                oi_reg    <= '0;
            end
            else if (pair_iss)
            begin
                if (lp_reg)
                begin
                    lp_reg <= 1'b0;
                end
                else if (CW'(pj_reg) == n_m1)
                begin
                    if (CW'(oi_reg) + CW'(1) == n_m1)
                    begin
                        pdone_reg <= 1'b1;
                    end
                    else
                    begin
                        oi_reg <= oi_reg + AW'(1);
                        lp_reg <= 1'b1;
                    end
                end
            end
            pair_rv_reg <= pair_iss;
            p1_v_reg    <= pair_rv_reg && !pair_ld_reg;
            p2_v_reg    <= p1_v_reg;
        end
    end

    // pair pipeline: differences, squares, strict-max compare
    assign sqx_full     = dx_reg * dx_reg;
    assign sqy_full     = dy_reg * dy_reg;
    assign pair_dsq     = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign pair_drained = pdone_reg && !pair_rv_reg && !p1_v_reg && !p2_v_reg;

    always_ff @(posedge clk)
    begin
        if (pair_iss)
        begin
            pj_reg <= lp_reg ? oi_reg + AW'(1) : pj_reg + AW'(1);
        end
        pair_ld_reg <= lp_reg;
        t0i_reg     <= oi_reg;
        t0j_reg     <= pj_reg;
        if (pair_rv_reg && pair_ld_reg)
        begin
            pix_reg <= rd_x;
            piy_reg <= rd_y;
        end
        dx_reg  <= (W+1)'(rd_x) - (W+1)'(pix_reg);
        dy_reg  <= (W+1)'(rd_y) - (W+1)'(piy_reg);
        t1i_reg <= t0i_reg;
        t1j_reg <= t0j_reg;
        sqx_reg <= sqx_full[SQ_W-1:0];
        sqy_reg <= sqy_full[SQ_W-1:0];
        t2i_reg <= t1i_reg;
        t2j_reg <= t1j_reg;
        // pair indices for the final midpoint read
        if (in_acc && vertex.last_vertex)
        begin
            bi_reg   <= '0;
            bj_reg   <= (n_now == CW'(1)) ? AW'(0) : AW'(1);
            best_reg <= '0;
        end
        else if (p2_v_reg && (pair_dsq > best_reg))
        begin
            best_reg <= pair_dsq;
            bi_reg   <= t2i_reg;
            bj_reg   <= t2j_reg;
        end
    end

    // midpoint read: vertex bi, then vertex bj
    assign mid_sx = (W+1)'(hold_x_reg) + (W+1)'(rd_x);
    assign mid_sy = (W+1)'(hold_y_reg) + (W+1)'(rd_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg <= 2'd0;
        end
        else if (state_reg == S_MID)
        begin
            mstep_reg <= (mstep_reg == 2'd2) ? 2'd0 : mstep_reg + 2'd1;
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (in_acc && vertex.last_vertex)
        begin
            n_reg        <= n_now;
            res_kind_reg <= (n_now == CW'(1)) ? KIND_POINT : KIND_MIDPOINT;
        end
        if ((state_reg == S_MID) && (mstep_reg == 2'd1))
        begin
            hold_x_reg <= rd_x;
            hold_y_reg <= rd_y;
        end
        if ((state_reg == S_MID) && (mstep_reg == 2'd2))
        begin
            res_x_reg <= mid_sx[W:1];
            res_y_reg <= mid_sy[W:1];
        end
        if (pair_drained && (state_reg == S_PAIR))
        begin
            res_kind_reg <= KIND_COLLINEAR;
        end
        if ((state_reg == S_DIVX) && div_st.done)
        begin
            res_x_reg <= quo_sat;
        end
        if ((state_reg == S_DIVY) && div_st.done)
        begin
            res_y_reg    <= quo_sat;
            res_kind_reg <= KIND_AREA;
        end
    end

    // output register
    assign out_load = (state_reg == S_DONE) && (!out_v_reg || centroid.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_v_reg <= 1'b1;
        end
        else if (centroid.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_kind_reg <= res_kind_reg;
        end
    end

    assign centroid.valid      = out_v_reg;
    assign centroid.centroid_x = out_x_reg;
    assign centroid.centroid_y = out_y_reg;
    assign centroid.case_kind  = out_kind_reg;

`ifndef SYNTHESIS
    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // division only starts with a nonzero denominator
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEN) |-> (den_reg != '0))
        else $error("division started with zero area");

    // divider finishes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider result with no consumer");

    // a new result beat comes only from the result wait state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside of result state");
`endif

endmodule

@@ dv/polygon_centroid_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_centroid_tb
// Streams polygons into the centroid block: a directed table of corner cases
// (single point, two points, triangles, collinear and coincident sets,
// overflowing centroids), then a full vertex store and random polygons.
// Each centroid beat is checked against an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module polygon_centroid_tb;
    import pc_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int CW           = 24;
    localparam int NUM_RANDOM   = 450;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t     x;
        coord_t     y;
        case_kind_t kind;
    } centroid_t;

    typedef struct {
        coord_t     x;
        coord_t     y;
        logic       last;
        logic       known;
        coord_t     ex;
        coord_t     ey;
        case_kind_t ekind;
    } vertex_row_t;

    logic clk;
    logic rst_n;

    vertex_if   #(.COORD_WIDTH(CW)) vtx ();
    centroid_if #(.COORD_WIDTH(CW)) cen ();

    polygon_centroid #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(CW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertex   (vtx.sink),
        .centroid (cen.source)
    );

    // predictor state
    longint    poly_x [MAX_VERTICES];
    longint    poly_y [MAX_VERTICES];
    int        poly_count;
    centroid_t centroid_queue [$];
    int        error_count;
    int        centroid_count;
    int        vertex_count_sent;
    longint    cycle_count;
    logic      stim_done;
    vertex_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_mid(longint a, longint b);
        return (a + b) >>> 1;
    endfunction

    function automatic coord_t clamp_coord(logic signed [127:0] v);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (CW - 1)) - 1;
        lo_lim = -(128'sd1 <<< (CW - 1));
        if (v > hi_lim)
            return hi_lim[CW-1:0];
        if (v < lo_lim)
            return lo_lim[CW-1:0];
        return v[CW-1:0];
    endfunction

    // truncating signed divide on wide values
    function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        un = n[127] ? -n : n;
        ud = d[127] ? -d : d;
        q  = un / ud;
        return (n[127] != d[127]) ? -$signed(q) : $signed(q);
    endfunction

    // fold one accepted vertex into the polygon, push a centroid on the last one
    task automatic predict_vertex(coord_t x, coord_t y, logic last);
        int n;
        int bi;
        int bj;
        logic signed [127:0] area;
        logic signed [127:0] sx;
        logic signed [127:0] sy;
        logic signed [127:0] cr;
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        logic [127:0] dsq;
        logic [127:0] best;
        centroid_t c;
        if (poly_count < MAX_VERTICES)
        begin
            poly_x[poly_count] = x;
            poly_y[poly_count] = y;
            poly_count++;
        end
        if (!last)
            return;
        n = poly_count;
        poly_count = 0;
        if (n == 1)
        begin
            c.x = coord_t'(poly_x[0]);
            c.y = coord_t'(poly_y[0]);
            c.kind = KIND_POINT;
        end
        else if (n == 2)
        begin
            c.x = coord_t'(floor_mid(poly_x[0], poly_x[1]));
            c.y = coord_t'(floor_mid(poly_y[0], poly_y[1]));
            c.kind = KIND_MIDPOINT;
        end
        else
        begin
            area = 0;
            sx = 0;
            sy = 0;
            for (int i = 0; i < n; i++)
            begin
                int k;
                k = (i + 1 < n) ? i + 1 : 0;
                cr = 128'(poly_x[i]) * 128'(poly_y[k]) - 128'(poly_x[k]) * 128'(poly_y[i]);
                area += cr;
                sx += 128'(poly_x[i] + poly_x[k]) * cr;
                sy += 128'(poly_y[i] + poly_y[k]) * cr;
            end
            if (area != 0)
            begin
                c.x = clamp_coord(div_trunc(sx, area * 3));
                c.y = clamp_coord(div_trunc(sy, area * 3));
                c.kind = KIND_AREA;
            end
            else
            begin
                best = 0;
                bi = 0;
                bj = 0;
                for (int i = 0; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                    begin
                        dx = poly_x[j] - poly_x[i];
                        dy = poly_y[j] - poly_y[i];
                        dsq = dx * dx + dy * dy;
                        if (dsq > best)
                        begin
                            best = dsq;
                            bi = i;
                            bj = j;
                        end
                    end
                c.x = coord_t'(floor_mid(poly_x[bi], poly_x[bj]));
                c.y = coord_t'(floor_mid(poly_y[bi], poly_y[bj]));
                c.kind = KIND_COLLINEAR;
            end
        end
        centroid_queue.push_back(c);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one vertex beat and wait for acceptance
    task automatic send_vertex(coord_t x, coord_t y, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx.valid       <= 1'b1;
        vtx.vertex_x    <= x;
        vtx.vertex_y    <= y;
        vtx.last_vertex <= last;
        // ready is settled at the falling edge, the beat goes at the next rising edge
        @(negedge clk);
        while (!vtx.ready)
            @(negedge clk);
        @(posedge clk);
        predict_vertex(x, y, last);
        vertex_count_sent++;
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
            default: return coord_t'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic add_row(coord_t x, coord_t y, logic last);
        vertex_row_t r;
        r.x = x;
        r.y = y;
        r.last = last;
        r.known = 1'b0;
        r.ex = 0;
        r.ey = 0;
        r.ekind = KIND_AREA;
        directed_rows.push_back(r);
    endtask

    task automatic add_known(coord_t x, coord_t y, coord_t ex, coord_t ey, case_kind_t k);
        vertex_row_t r;
        r.x = x;
        r.y = y;
        r.last = 1'b1;
        r.known = 1'b1;
        r.ex = ex;
        r.ey = ey;
        r.ekind = k;
        directed_rows.push_back(r);
    endtask

    // stimulus
    initial
    begin
        coord_t cmax;
        coord_t cmin;
        int mode;
        int nv;
        int kind_sel;
        coord_t bx;
        coord_t by;
        coord_t ddx;
        coord_t ddy;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        rst_n = 1'b0;
        vtx.valid <= 1'b0;
        vtx.vertex_x <= '0;
        vtx.vertex_y <= '0;
        vtx.last_vertex <= 1'b0;
        stim_done = 1'b0;
        poly_count = 0;
        vertex_count_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single points at the extremes and at the origin
        add_known(cmax, cmin, cmax, cmin, KIND_POINT);
        add_known(cmin, cmax, cmin, cmax, KIND_POINT);
        add_known(24'sd0, 24'sd0, 24'sd0, 24'sd0, KIND_POINT);
        // two-point midpoint, floor on odd negative sum
        add_row(24'sd0, 24'sd0, 1'b0);
        add_known(-24'sd3, 24'sd5, -24'sd2, 24'sd2, KIND_MIDPOINT);
        add_row(cmin, cmin, 1'b0);
        add_known(cmin, cmin, cmin, cmin, KIND_MIDPOINT);
        // triangle (0,0)(6,0)(0,6): centroid (2,2)
        add_row(24'sd0, 24'sd0, 1'b0);
        add_row(24'sd6, 24'sd0, 1'b0);
        add_known(24'sd0, 24'sd6, 24'sd2, 24'sd2, KIND_AREA);
        // collinear: farthest pair is (0,0)-(10,10)
        add_row(24'sd0, 24'sd0, 1'b0);
        add_row(24'sd10, 24'sd10, 1'b0);
        add_known(24'sd4, 24'sd4, 24'sd5, 24'sd5, KIND_COLLINEAR);
        // all coincident: vertex 0
        add_row(24'sd7, -24'sd9, 1'b0);
        add_row(24'sd7, -24'sd9, 1'b0);
        add_known(24'sd7, -24'sd9, 24'sd7, -24'sd9, KIND_COLLINEAR);
        // extreme triangle and a self-intersecting bow tie that may saturate
        add_row(cmin, cmin, 1'b0);
        add_row(cmax, cmin, 1'b0);
        add_row(cmax, cmax, 1'b1);
        add_row(24'sd0, 24'sd0, 1'b0);
        add_row(cmax, 24'sd1, 1'b0);
        add_row(cmax, 24'sd0, 1'b0);
        add_row(24'sd0, 24'sd2, 1'b1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
                assert (directed_rows[i].last);
            send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last);
            if (directed_rows[i].known)
            begin
                centroid_t c;
                c = centroid_queue[$];
                if (c.x !== directed_rows[i].ex || c.y !== directed_rows[i].ey
                    || c.kind !== directed_rows[i].ekind)
                begin
                    $error("directed row %0d: table %0d,%0d,%s predictor %0d,%0d,%s", i,
                           directed_rows[i].ex, directed_rows[i].ey,
                           directed_rows[i].ekind.name(), c.x, c.y, c.kind.name());
                    error_count++;
                end
            end
        end

        // store full: 66 vertices, the last two dropped
        for (int i = 0; i < MAX_VERTICES + 2; i++)
            send_vertex(rand_coord(1), rand_coord(1), i == MAX_VERTICES + 1);

        // random polygons
        while (vertex_count_sent < NUM_RANDOM)
        begin
            mode = $urandom_range(0, 2);
            kind_sel = $urandom_range(0, 9);
            nv = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
            bx = rand_coord(mode);
            by = rand_coord(mode);
            ddx = rand_coord(1);
            ddy = rand_coord(1);
            for (int i = 0; i < nv; i++)
            begin
                if (kind_sel < 2)
                    // points offset from the base by independent multiples of ddx and ddy
                    send_vertex(bx + coord_t'($signed($urandom_range(0, 6)) - 3) * ddx,
                                by + coord_t'($signed($urandom_range(0, 6)) - 3) * ddy,
                                i == nv - 1);
                else
                    send_vertex(rand_coord(mode), rand_coord(mode), i == nv - 1);
            end
        end
        vtx.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // centroid sink with random backpressure
    initial
    begin
        int stall;
        centroid_t expv;
        cen.ready <= 1'b0;
        error_count = 0;
        centroid_count = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                cen.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cen.ready <= 1'b1;
            // sample the beat that the next rising edge accepts
            @(negedge clk);
            if (cen.valid && cen.ready)
            begin
                if (centroid_queue.size() == 0)
                begin
                    $error("centroid beat with nothing expected");
                    error_count++;
                end
                else
                begin
                    expv = centroid_queue.pop_front();
                    centroid_count++;
                    if (cen.centroid_x !== expv.x)
                    begin
                        $error("centroid_x expected %0d got %0d", expv.x, cen.centroid_x);
                        error_count++;
                    end
                    if (cen.centroid_y !== expv.y)
                    begin
                        $error("centroid_y expected %0d got %0d", expv.y, cen.centroid_y);
                        error_count++;
                    end
                    if (cen.case_kind !== expv.kind)
                    begin
                        $error("case_kind expected %s got %0d", expv.kind.name(),
                               cen.case_kind);
                        error_count++;
                    end
                end
            end
            @(posedge clk);
        end
    end

    // end of run and timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
            if (stim_done && centroid_queue.size() == 0)
            begin
                repeat (6000) @(posedge clk);
                $display("sent %0d vertices, checked %0d centroids (all four cases)",
                         vertex_count_sent, centroid_count);
                if (error_count == 0 && centroid_queue.size() == 0)
                    $display("end of test: clean");
                else
                    $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
